// ----- rtl/core/bdvp_pkg.sv -----
package bdvp_pkg;

  // Position width; the position, multiplier and root widths below follow from it (range 16 to 32)
  localparam int unsigned POSITION_BITS = 24;
  localparam int unsigned POS_W         = POSITION_BITS;

  localparam int unsigned TGT_W      = 24;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Remaining distance holds both the travelled root and the target magnitude
  localparam int unsigned REM_W    = (POS_W + 1 > TGT_W) ? POS_W + 1 : TGT_W;
  localparam int unsigned MUL_A_W  = REM_W;
  localparam int unsigned MUL_B_W  = POS_W;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SQ_SUM_W = 2 * POS_W + 1;
  localparam int unsigned VRAD_W   = REM_W + ACC_W + 1;
  localparam int unsigned RAD_W0   = (SQ_SUM_W > VRAD_W) ? SQ_SUM_W : VRAD_W;
  localparam int unsigned RAD_W    = RAD_W0 + (RAD_W0 % 2);
  localparam int unsigned ROOT_W   = RAD_W / 2;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_MOVING    = 3'd0;
  localparam logic [STAT_W-1:0] ST_ARRIVED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STAT_W-1:0] ST_POSE_LOST = 3'd3;
  localparam logic [STAT_W-1:0] ST_IDLE      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VMIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX   = 3'd4;

  localparam logic signed [TGT_W-1:0] TGT_RST  = 24'sd500;
  localparam logic [TOL_W-1:0]        TOL_RST  = 16'd100;
  localparam logic [ACC_W-1:0]        ACC_RST  = 16'd500;
  localparam logic signed [VEL_W-1:0] VMIN_RST = -16'sd250;
  localparam logic signed [VEL_W-1:0] VMAX_RST = 16'sd250;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    pose_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic [STAT_W-1:0]       status;
  } out_item_t;

endpackage

// ----- rtl/core/bdvp_mul.sv -----
module bdvp_mul
  import bdvp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_P_W-1:0] prod_q, prod_d;
  logic [MUL_A_W:0]   psum;

  // Add the multiplicand into the upper half when the low multiplier bit is set
  assign psum = {1'b0, prod_q[MUL_P_W-1:MUL_B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MUL_B_W);
      prod_d = {{MUL_A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q - CNT_W'(1);
        prod_d = {psum, prod_q[MUL_B_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = prod_q;

endmodule

// ----- rtl/core/bdvp_sqrt.sv -----
module bdvp_sqrt
  import bdvp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+2:0] shifted, trial, diff;
  logic              ge;

  // One root bit per cycle: bring down the next pair, try 4*root+1
  assign shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q - CNT_W'(1);
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        rem_d  = ge ? diff[ROOT_W:0] : shifted[ROOT_W:0];
        root_d = {root_q[ROOT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

endmodule

// ----- rtl/core/backup_distance_velocity_profile.sv -----
// Velocity profile for a straight back-up move over a set signed distance.
// Input channel (in_valid_i / in_stall_o / in_data_i): one item per command:
// start (latch the pose as start point), pose sample, or cancel. Every item
// yields exactly one result item (velocity, status) on the output channel
// (out_valid_o / out_stall_i / out_data_o).
// Configuration port (cfg_valid_i / cfg_ready_o): always ready; write target
// distance, tolerance, deceleration limit and velocity clamps while idle.
// Sequencing: start, cancel, idle samples, lost poses and the unused op pass
// from acceptance through the result register and the done state into the
// output register; the sequencer then returns to idle for the next item.
// A moving sample runs a two-lane bit-serial square of dx and dy and a
// bit-serial square root of the sum; unless within tolerance, it then runs a
// bit-serial multiply of the remaining distance by the deceleration limit,
// a second root and a clamp. One item is in flight at a time; the multiplier
// and root units work one bit per cycle.
// Reset: registers take their documented reset values, start point is zero,
// the move is disarmed. A stalled result holds in the output register; the
// next result waits in a holding stage, and input is stalled until it moves.
module backup_distance_velocity_profile
  import bdvp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_ROOT1 = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_ROOT2 = 3'd5;
  localparam logic [2:0] S_CLAMP = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic signed [VEL_W-1:0] VEL_NEG_MAX = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_POS_MAX = ~VEL_NEG_MAX;

  // Configuration registers
  logic signed [TGT_W-1:0] tgt_q;
  logic [TOL_W-1:0]        tol_q;
  logic [ACC_W-1:0]        acc_q;
  logic signed [VEL_W-1:0] vmin_q;
  logic signed [VEL_W-1:0] vmax_q;
  logic                    cfg_we;

  // Move state and sequencer
  logic [2:0]              state_q, state_d;
  logic                    moving_q, moving_d;
  logic signed [POS_W-1:0] start_x_q, start_x_d;
  logic signed [POS_W-1:0] start_y_q, start_y_d;
  out_item_t               res_q, res_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [ROOT_W-1:0]       vroot_q;
  logic                    in_acc;
  logic                    sq_go;
  logic                    arrive;

  // Output register
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q;
  logic                    out_free;

  // Datapath
  logic signed [POS_W:0]   dxs, dys;
  logic [POS_W:0]          dxm, dym;
  logic                    mx_start, mx_done, my_done, sq_start, sq_done;
  logic [MUL_A_W-1:0]      mx_a;
  logic [MUL_B_W-1:0]      mx_b;
  logic [MUL_P_W-1:0]      mx_prod, my_prod;
  logic [SQ_SUM_W-1:0]     sum_sq;
  logic [RAD_W-1:0]        rad;
  logic [ROOT_W-1:0]       root;
  logic [TGT_W-1:0]        tgt_mag;
  logic [REM_W-1:0]        tgt_mag_r, trav;
  logic signed [ROOT_W:0]  v_ext, vmin_ext, vmax_ext, v_lo, v_hi;
  logic signed [VEL_W-1:0] v_clamp, v_signed;

  // ---------------------------------------------------------------------------
  // Configuration writes; the port never pushes back
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= TGT_RST;
      tol_q  <= TOL_RST;
      acc_q  <= ACC_RST;
      vmin_q <= VMIN_RST;
      vmax_q <= VMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_TARGET: tgt_q  <= cfg_data_i[TGT_W-1:0];
        CFG_TOL:    tol_q  <= cfg_data_i[TOL_W-1:0];
        CFG_ACC:    acc_q  <= cfg_data_i[ACC_W-1:0];
        CFG_VMIN:   vmin_q <= cfg_data_i[VEL_W-1:0];
        CFG_VMAX:   vmax_q <= cfg_data_i[VEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take an item only when the sequencer is free
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Offsets from the start point, folded to magnitudes
  assign dxs = {start_x_q[POS_W-1], start_x_q} - {in_data_i.pos_x[POS_W-1], in_data_i.pos_x};
  assign dys = {start_y_q[POS_W-1], start_y_q} - {in_data_i.pos_y[POS_W-1], in_data_i.pos_y};
  assign dxm = dxs[POS_W] ? -dxs : dxs;
  assign dym = dys[POS_W] ? -dys : dys;

  // Armed sample with a good pose: launch both squaring lanes on acceptance
  assign sq_go = in_acc && (in_data_i.op == OP_SAMPLE) && moving_q && in_data_i.pose_ok;

  assign arrive = rem_q < REM_W'(tol_q);

  // Lane x is reused for remaining distance times deceleration limit
  assign mx_start = sq_go || ((state_q == S_REM) && !arrive);
  assign mx_a     = (state_q == S_REM) ? rem_q : MUL_A_W'(dxm[POS_W-1:0]);
  assign mx_b     = (state_q == S_REM) ? MUL_B_W'(acc_q) : dxm[POS_W-1:0];

  bdvp_mul u_mul_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mx_start),
    .a_i     (mx_a),
    .b_i     (mx_b),
    .done_o  (mx_done),
    .prod_o  (mx_prod)
  );

  bdvp_mul u_mul_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_go),
    .a_i     (MUL_A_W'(dym[POS_W-1:0])),
    .b_i     (dym[POS_W-1:0]),
    .done_o  (my_done),
    .prod_o  (my_prod)
  );

  // Radicand: dx^2 + dy^2 for the distance travelled, then 2*acc*remaining
  assign sum_sq   = {1'b0, mx_prod[2*POS_W-1:0]} + {1'b0, my_prod[2*POS_W-1:0]};
  assign sq_start = ((state_q == S_SQ) && mx_done && my_done)
                 || ((state_q == S_MUL2) && mx_done);
  assign rad      = (state_q == S_MUL2) ? RAD_W'({mx_prod[VRAD_W-2:0], 1'b0})
                                        : RAD_W'(sum_sq);

  bdvp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Remaining distance from the target magnitude
  assign tgt_mag   = tgt_q[TGT_W-1] ? (~tgt_q + 1'b1) : tgt_q;
  assign tgt_mag_r = REM_W'(tgt_mag);
  assign trav      = REM_W'(root);

  // Clamp low then high, so that the upper bound wins when they cross
  assign v_ext    = {1'b0, vroot_q};
  assign vmin_ext = (ROOT_W+1)'(vmin_q);
  assign vmax_ext = (ROOT_W+1)'(vmax_q);
  assign v_lo     = (v_ext < vmin_ext) ? vmin_ext : v_ext;
  assign v_hi     = (v_lo > vmax_ext) ? vmax_ext : v_lo;
  assign v_clamp  = v_hi[VEL_W-1:0];
  // Apply the direction; saturate the one value that has no negation
  assign v_signed = !tgt_q[TGT_W-1] ? v_clamp
                  : (v_clamp == VEL_NEG_MAX) ? VEL_POS_MAX : -v_clamp;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    moving_d  = moving_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    res_d     = res_q;
    rem_d     = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d.velocity = '0;
          state_d        = S_DONE;
          unique case (in_data_i.op)
            OP_START: begin
              if (in_data_i.pose_ok) begin
                start_x_d    = in_data_i.pos_x;
                start_y_d    = in_data_i.pos_y;
                moving_d     = 1'b1;
                res_d.status = ST_MOVING;
              end else begin
                moving_d     = 1'b0;
                res_d.status = ST_POSE_LOST;
              end
            end
            OP_SAMPLE: begin
              if (!moving_q) begin
                res_d.status = ST_IDLE;
              end else if (!in_data_i.pose_ok) begin
                moving_d     = 1'b0;
                res_d.status = ST_POSE_LOST;
              end else begin
                state_d = S_SQ;
              end
            end
            OP_CANCEL: begin
              moving_d     = 1'b0;
              res_d.status = ST_CANCELLED;
            end
            OP_UNUSED: begin
              res_d.status = moving_q ? ST_MOVING : ST_IDLE;
            end
          endcase
        end
      end
      S_SQ: begin
        if (mx_done && my_done) begin
          state_d = S_ROOT1;
        end
      end
      S_ROOT1: begin
        if (sq_done) begin
          rem_d   = (tgt_mag_r > trav) ? (tgt_mag_r - trav) : (trav - tgt_mag_r);
          state_d = S_REM;
        end
      end
      S_REM: begin
        if (arrive) begin
          moving_d       = 1'b0;
          res_d.velocity = '0;
          res_d.status   = ST_ARRIVED;
          state_d        = S_DONE;
        end else begin
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mx_done) begin
          state_d = S_ROOT2;
        end
      end
      S_ROOT2: begin
        if (sq_done) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        res_d.velocity = v_signed;
        res_d.status   = ST_MOVING;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      moving_q    <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      moving_q    <= moving_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    rem_q <= rem_d;
    if ((state_q == S_ROOT2) && sq_done) begin
      vroot_q <= root;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_cancel_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.op == OP_CANCEL)) |=> !moving_q)
    else $error("cancel left the move armed");

  a_profile_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MUL2) || (state_q == S_ROOT2) || (state_q == S_CLAMP)) |-> moving_q)
    else $error("velocity computed while the move is not armed");

  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> (mx_done == my_done))
    else $error("squaring lanes finished apart");

  a_units_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mx_done, sq_done}))
    else $error("multiplier and root unit finished together");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_MOVING)) |-> (out_data_o.velocity == '0))
    else $error("non-moving result carries a velocity");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bdvp_pkg::*;

  // Run length guard: roughly 1200 items, each with its root and multiply
  // work, plus long receiver stalls, taken several times over.
  localparam int LIMIT_CYCLES  = 1_500_000;
  // Cycles to let pass once nothing is expected: longer than a moving sample.
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 127;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  backup_distance_velocity_profile u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the configuration registers, as the block should hold them
  logic signed [TGT_W-1:0] target_q = TGT_RST;
  logic [TOL_W-1:0]        tol_q    = TOL_RST;
  logic [ACC_W-1:0]        acc_q    = ACC_RST;
  logic signed [VEL_W-1:0] vmin_q   = VMIN_RST;
  logic signed [VEL_W-1:0] vmax_q   = VMAX_RST;

  // Shadow move state: latched start point and whether a move is armed
  logic signed [POS_W-1:0] origin_x = '0;
  logic signed [POS_W-1:0] origin_y = '0;
  bit                      armed    = 1'b0;

  out_item_t commands_due[$];
  int        items_sent     = 0;
  int        mismatch_cnt   = 0;
  int        cycle_cnt      = 0;
  int        send_idle_pct  = 18;
  int        recv_stall_pct = 82;

  // One row of the directed part: either a register write or an item,
  // the latter with its result typed in where it is obvious.
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  dir_row_t dir_table[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  // Floor square root, two bits of radicand per step
  function automatic longint unsigned int_sqrt(input longint unsigned rad);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    int              i;
    root = 0;
    rem  = 0;
    for (i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_TARGET: target_q = val[TGT_W-1:0];
      CFG_TOL:    tol_q    = val[TOL_W-1:0];
      CFG_ACC:    acc_q    = val[ACC_W-1:0];
      CFG_VMIN:   vmin_q   = val[VEL_W-1:0];
      CFG_VMAX:   vmax_q   = val[VEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Work out the velocity command for one item and advance the move state.
  function automatic out_item_t next_command(input in_item_t it);
    out_item_t r;
    longint    dx, dy, trav, tgt, remaining, v;
    longint    tol_l, acc_l, vmin_l, vmax_l, ox, oy, px, py;
    r.velocity = '0;
    r.status   = ST_IDLE;
    case (it.op)
      OP_START: begin
        if (it.pose_ok) begin
          origin_x = it.pos_x;
          origin_y = it.pos_y;
          armed    = 1'b1;
          r.status = ST_MOVING;
        end else begin
          armed    = 1'b0;
          r.status = ST_POSE_LOST;
        end
      end
      OP_CANCEL: begin
        armed    = 1'b0;
        r.status = ST_CANCELLED;
      end
      OP_SAMPLE: begin
        if (!armed) begin
          r.status = ST_IDLE;
        end else if (!it.pose_ok) begin
          armed    = 1'b0;
          r.status = ST_POSE_LOST;
        end else begin
          ox = longint'(origin_x);
          oy = longint'(origin_y);
          px = longint'(it.pos_x);
          py = longint'(it.pos_y);
          dx = ox - px;
          dy = oy - py;
          trav = int_sqrt(dx * dx + dy * dy);
          tgt  = longint'(target_q);
          if (tgt < 0) tgt = -tgt;
          remaining = (tgt > trav) ? tgt - trav : trav - tgt;
          tol_l  = longint'(tol_q);
          acc_l  = longint'(acc_q);
          vmin_l = longint'(vmin_q);
          vmax_l = longint'(vmax_q);
          if (remaining < tol_l) begin
            armed    = 1'b0;
            r.status = ST_ARRIVED;
          end else begin
            v = int_sqrt(2 * acc_l * remaining);
            // max clamp last, so crossed bounds give the upper one
            if (v < vmin_l) v = vmin_l;
            if (v > vmax_l) v = vmax_l;
            if (target_q < 0) v = -v;
            if (v > 32767) v = 32767;
            r.velocity = v[VEL_W-1:0];
            r.status   = ST_MOVING;
          end
        end
      end
      default: r.status = armed ? ST_MOVING : ST_IDLE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Receiver: stall at random, changed at the falling edge
  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  // Compare each accepted result with the oldest outstanding command
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (commands_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: velocity %0d status %0d",
                                  out_data_o.velocity, out_data_o.status));
      end else begin
        want = commands_due.pop_front();
        if (out_data_o.velocity !== want.velocity)
          report_mismatch($sformatf("velocity got %0d want %0d", out_data_o.velocity,
                                    want.velocity));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_data_o.status,
                                    want.status));
      end
    end
  end

  // Enter and leave at a falling edge. Hold the item until accepted; leave
  // valid high so the next item can follow without a gap.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = next_command(it);
    commands_due.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_plain(input in_item_t it);
    push_item(it, 1'b0, '0);
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (commands_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t item_row(input logic [OP_W-1:0] op, input int x, input int y,
                                        input bit ok, input bit typed, input int vel,
                                        input logic [STAT_W-1:0] st);
    dir_row_t row;
    row.is_reg          = 1'b0;
    row.reg_idx         = '0;
    row.reg_val         = '0;
    row.item.op         = op;
    row.item.pos_x      = x[POS_W-1:0];
    row.item.pos_y      = y[POS_W-1:0];
    row.item.pose_ok    = ok;
    row.typed           = typed;
    row.want.velocity   = vel[VEL_W-1:0];
    row.want.status     = st;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    dir_row_t row;
    row         = item_row(OP_START, 0, 0, 1'b0, 1'b0, 0, ST_IDLE);
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val[CFG_DATA_W-1:0];
    return row;
  endfunction

  // Load one setting of all five registers: two fixed sets of extremes, then
  // random sets biased towards sizes where moves run over several samples.
  task automatic load_settings(input int ph);
    int                      tg, tl, ac, lo, hi;
    logic signed [TGT_W-1:0] r24;
    logic signed [VEL_W-1:0] r16;
    case (ph)
      0: begin
        tg = -8388608; tl = 0; ac = 65535; lo = -32768; hi = 32767;
      end
      1: begin
        tg = 8388607; tl = 65535; ac = 0; lo = 32767; hi = -32768;
      end
      default: begin
        r24 = TGT_W'($urandom());
        case ($urandom_range(0, 9))
          0:       tg = 0;
          1:       tg = int'(r24);
          default: tg = $urandom_range(0, 1) ? int'($urandom_range(50, 5000))
                                             : -int'($urandom_range(50, 5000));
        endcase
        case ($urandom_range(0, 9))
          0:       tl = 0;
          1:       tl = $urandom_range(0, 65535);
          default: tl = $urandom_range(0, 300);
        endcase
        ac = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(1, 3000));
        r16 = VEL_W'($urandom());
        case ($urandom_range(0, 9))
          0:       lo = int'(r16);
          1:       lo = -int'($urandom_range(0, 500));
          default: lo = $urandom_range(0, 100);
        endcase
        r16 = VEL_W'($urandom());
        hi = ($urandom_range(0, 9) == 0) ? int'(r16) : int'($urandom_range(50, 2000));
      end
    endcase
    write_reg(CFG_TARGET, tg);
    write_reg(CFG_TOL, tl);
    write_reg(CFG_ACC, ac);
    write_reg(CFG_VMIN, lo);
    write_reg(CFG_VMAX, hi);
  endtask

  // One well-formed move: a start, then samples walking out along a line past
  // the target distance, with the odd lost pose, cancel, unused op or restart mixed in.
  task automatic run_move();
    longint                  tgt_mag, span, d, sx, sy, ax, ay, len, px, py, tol_l;
    int                      steps, j, pick;
    logic signed [POS_W-1:0] r_pos;
    in_item_t                it;
    tgt_mag = longint'(target_q);
    if (tgt_mag < 0) tgt_mag = -tgt_mag;
    tol_l = longint'(tol_q);
    span  = tgt_mag + tol_l + longint'($urandom_range(0, 200));
    if ($urandom_range(0, 9) == 0) begin
      r_pos = POS_W'($urandom());
      sx    = longint'(r_pos);
      r_pos = POS_W'($urandom());
      sy    = longint'(r_pos);
    end else begin
      sx = longint'($urandom_range(0, 20000)) - 10000;
      sy = longint'($urandom_range(0, 20000)) - 10000;
    end
    case ($urandom_range(0, 2))
      0:       begin ax = 1; ay = 0; end
      1:       begin ax = 0; ay = 1; end
      default: begin
        ax = longint'($urandom_range(1, 1000));
        ay = longint'($urandom_range(0, 1000));
      end
    endcase
    if ($urandom_range(0, 1)) ax = -ax;
    if ($urandom_range(0, 1)) ay = -ay;
    len = int_sqrt(ax * ax + ay * ay);

    it.op      = OP_START;
    it.pos_x   = sx[POS_W-1:0];
    it.pos_y   = sy[POS_W-1:0];
    it.pose_ok = ($urandom_range(0, 19) != 0);
    push_plain(it);

    steps = $urandom_range(2, 12);
    for (j = 1; j <= steps; j++) begin
      d = span * longint'(j) / longint'(steps);
      if ($urandom_range(0, 3) == 0) d = d + longint'($urandom_range(0, 20)) - 10;
      px         = sx + d * ax / len;
      py         = sy + d * ay / len;
      it.op      = OP_SAMPLE;
      it.pos_x   = px[POS_W-1:0];
      it.pos_y   = py[POS_W-1:0];
      it.pose_ok = 1'b1;
      pick       = $urandom_range(0, 99);
      if (pick < 4)       it.pose_ok = 1'b0;
      else if (pick < 7)  it.op      = OP_CANCEL;
      else if (pick < 10) it.op      = OP_UNUSED;
      else if (pick < 13) it.op      = OP_START;
      push_plain(it);
    end
  endtask

  // Noise: any op, any position, either pose flag
  task automatic push_noise();
    in_item_t it;
    it.op      = OP_W'($urandom_range(0, 3));
    it.pos_x   = POS_W'($urandom());
    it.pos_y   = POS_W'($urandom());
    it.pose_ok = 1'($urandom_range(0, 1));
    push_plain(it);
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;
    int k;

    // Directed part, from the reset settings onwards
    dir_table.push_back(item_row(OP_SAMPLE, 0, 0, 1'b1, 1'b1, 0, ST_IDLE));
    dir_table.push_back(item_row(OP_UNUSED, 0, 0, 1'b1, 1'b1, 0, ST_IDLE));
    dir_table.push_back(item_row(OP_CANCEL, 0, 0, 1'b1, 1'b1, 0, ST_CANCELLED));
    dir_table.push_back(item_row(OP_START, 0, 0, 1'b1, 1'b1, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_UNUSED, 0, 0, 1'b1, 1'b1, 0, ST_MOVING));
    // far from target: the upper clamp holds the command
    dir_table.push_back(item_row(OP_SAMPLE, 0, 0, 1'b1, 1'b1, 250, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, 300, 400, 1'b1, 1'b1, 0, ST_ARRIVED));
    dir_table.push_back(item_row(OP_SAMPLE, 300, 400, 1'b1, 1'b1, 0, ST_IDLE));
    dir_table.push_back(item_row(OP_START, 7, 7, 1'b0, 1'b1, 0, ST_POSE_LOST));
    dir_table.push_back(item_row(OP_START, -8388608, 8388607, 1'b1, 1'b1, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, 8388607, -8388608, 1'b1, 1'b0, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, 1, 1, 1'b0, 1'b1, 0, ST_POSE_LOST));
    dir_table.push_back(item_row(OP_START, 100, -100, 1'b1, 1'b1, 0, ST_MOVING));
    // restart while moving
    dir_table.push_back(item_row(OP_START, 200, -100, 1'b1, 1'b1, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_CANCEL, 0, 0, 1'b1, 1'b1, 0, ST_CANCELLED));
    // reverse move with both clamps at the bottom: negation saturates
    dir_table.push_back(reg_row(CFG_TARGET, -1000));
    dir_table.push_back(reg_row(CFG_VMIN, -32768));
    dir_table.push_back(reg_row(CFG_VMAX, -32768));
    dir_table.push_back(item_row(OP_START, 0, 0, 1'b1, 1'b1, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, 0, 0, 1'b1, 1'b1, 32767, ST_MOVING));
    // crossed clamp bounds: the upper bound wins
    dir_table.push_back(reg_row(CFG_VMIN, 300));
    dir_table.push_back(reg_row(CFG_VMAX, 200));
    dir_table.push_back(item_row(OP_SAMPLE, -7, 0, 1'b1, 1'b1, -200, ST_MOVING));
    // zero tolerance never arrives; zero deceleration commands zero
    dir_table.push_back(reg_row(CFG_ACC, 0));
    dir_table.push_back(reg_row(CFG_TOL, 0));
    dir_table.push_back(reg_row(CFG_VMIN, 0));
    dir_table.push_back(reg_row(CFG_VMAX, 32767));
    dir_table.push_back(item_row(OP_SAMPLE, 0, 1000, 1'b1, 1'b1, 0, ST_MOVING));
    // widest tolerance: arrive at once
    dir_table.push_back(reg_row(CFG_TOL, 65535));
    dir_table.push_back(reg_row(CFG_ACC, 65535));
    dir_table.push_back(item_row(OP_SAMPLE, 0, 5, 1'b1, 1'b1, 0, ST_ARRIVED));
    dir_table.push_back(reg_row(CFG_TOL, 10));
    dir_table.push_back(reg_row(CFG_ACC, 500));
    dir_table.push_back(reg_row(CFG_VMIN, -250));
    dir_table.push_back(reg_row(CFG_VMAX, 250));
    dir_table.push_back(item_row(OP_START, 5, 5, 1'b1, 1'b1, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, 8, 9, 1'b1, 1'b0, 0, ST_MOVING));
    dir_table.push_back(item_row(OP_SAMPLE, -8388608, -1, 1'b1, 1'b0, 0, ST_MOVING));

    // Hold reset, then release at a falling edge
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the table; registers change only once the block has gone quiet
    for (k = 0; k < dir_table.size(); k++) begin
      if (dir_table[k].is_reg) begin
        drain_results();
        write_reg(dir_table[k].reg_idx, int'(dir_table[k].reg_val));
      end else begin
        push_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);
      end
    end

    // Random part: a new register setting per phase; swap the idling
    // pattern a third of the way in, and drop it for the last third.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == PHASES / 3) begin
        send_idle_pct  = 82;
        recv_stall_pct = 18;
      end else if (ph == 2 * PHASES / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      load_settings(ph);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 75) run_move();
        else push_noise();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
